// ===== src/eut_pkg.sv =====
// shared constants, types and helpers for the encoder unwrap velocity tracker
`timescale 1ns / 1ps
`default_nettype none
package eut_pkg;

  localparam int RawBits  = 15;
  localparam int DiffW    = 18;
  localparam int MagW     = 49;
  localparam int ProdW    = 80;
  localparam int DivW     = 28;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCpr  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInv  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGain = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnit = 2'd3;

  // unit codes
  localparam logic [1:0] UnitDeg = 2'd0;
  localparam logic [1:0] UnitRad = 2'd1;
  localparam logic [1:0] UnitRot = 2'd2;

  localparam logic [31:0] MulDeg   = 32'd23592960;
  localparam logic [31:0] MulRad   = 32'd1686629713;
  localparam logic [31:0] MulRot   = 32'd65536;
  localparam logic [31:0] UsPerSec = 32'd1000000;
  localparam logic [16:0] QOne     = 17'd65536;

  localparam logic [MagW-1:0] MagCap = 49'h1_0000_0000_0000;
  localparam logic [MagW-1:0] Mag47  = 49'h0_8000_0000_0000;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] mag;
  } div_rsp_t;

  // apply sign and saturate a magnitude to 48 bits
  function automatic logic [47:0] sign_sat(input logic [MagW-1:0] mag, input logic neg);
    logic [47:0] r;
    if (neg) begin
      r = (mag >= Mag47) ? 48'h8000_0000_0000 : (~mag[47:0] + 48'd1);
    end else begin
      r = (mag[48:47] != 2'b00) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/eut_mul.sv =====
// shared signed 33 x 33 multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module eut_mul (
  input  wire                clk_i,
  input  wire  signed [32:0] a_i,
  input  wire  signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== src/eut_div.sv =====
// radix-2 restoring divider with saturation and round half up
`timescale 1ns / 1ps
`default_nettype none
module eut_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire eut_pkg::div_req_t req_i,
  output eut_pkg::div_rsp_t   rsp_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [5:0]                 cnt_q;
  logic [eut_pkg::DivW-1:0]   rem_q;
  logic [eut_pkg::DivW-1:0]   d_q;
  logic [eut_pkg::MagW-1:0]   low_q;
  logic [eut_pkg::MagW-1:0]   quo_q;
  logic                       ovf_q;

  logic [eut_pkg::DivW:0]     trial;
  logic [eut_pkg::DivW:0]     trial_sub;
  logic                       ge;
  logic                       rnd;

  assign trial     = {rem_q, low_q[eut_pkg::MagW-1]};
  assign ge        = trial >= {1'b0, d_q};
  assign trial_sub = trial - {1'b0, d_q};
  assign rnd       = {rem_q, 1'b0} >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      d_q    <= '0;
      low_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        // quotient at or above 2^49 cannot fit the step count
        ovf_q  <= req_i.dividend[eut_pkg::ProdW-1:eut_pkg::MagW] >= {3'b000, req_i.divisor};
        rem_q  <= req_i.dividend[eut_pkg::MagW+eut_pkg::DivW-1:eut_pkg::MagW];
        low_q  <= req_i.dividend[eut_pkg::MagW-1:0];
        quo_q  <= '0;
        d_q    <= req_i.divisor;
        cnt_q  <= 6'(eut_pkg::MagW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? trial_sub[eut_pkg::DivW-1:0] : trial[eut_pkg::DivW-1:0];
        low_q <= {low_q[eut_pkg::MagW-2:0], 1'b0};
        quo_q <= {quo_q[eut_pkg::MagW-2:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mag  = (ovf_q || quo_q[eut_pkg::MagW-1]) ? eut_pkg::MagCap
                    : quo_q + {{(eut_pkg::MagW-1){1'b0}}, rnd};

endmodule
`default_nettype wire

// ===== src/encoder_unwrap_velocity_tracker_unit.sv =====
// top level: multi-turn unwrap, smoothed velocity and unit scaling sequencer
// a sample update runs the speed estimate, smoothing and then two scalings;
//   a zero command or a zero time step runs only the two scalings; when the
//   unit code is unused, no scaling runs and angle and speed report zero
// each scaling and the speed estimate is a multiply-divide on the shared
//   multiplier and divider (49 quotient steps); smoothing runs S_SM0 to S_SM5
// one word at a time: input stalls from accept until the result is registered
// reset: registers to defaults, position, speed and last sample cleared
`timescale 1ns / 1ps
`default_nettype none
module encoder_unwrap_velocity_tracker_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire                             command_i,
  input  wire  [14:0]                     raw_angle_i,
  input  wire  [19:0]                     dt_us_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic signed [31:0]              turn_count_o,
  output logic signed [47:0]              angle_value_o,
  output logic signed [47:0]              speed_value_o,
  output logic                            updated_o,
  input  wire                             cfg_we_i,
  input  wire  [eut_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [eut_pkg::CfgDataW-1:0]    cfg_data_i
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MLO    = 4'd1;
  localparam logic [3:0] S_MHI    = 4'd2;
  localparam logic [3:0] S_MACC   = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DWAIT  = 4'd5;
  localparam logic [3:0] S_SM0    = 4'd6;
  localparam logic [3:0] S_SM1    = 4'd7;
  localparam logic [3:0] S_SM2    = 4'd8;
  localparam logic [3:0] S_SM3    = 4'd9;
  localparam logic [3:0] S_SM4    = 4'd10;
  localparam logic [3:0] S_SM5    = 4'd11;
  localparam logic [3:0] S_SPOS   = 4'd12;
  localparam logic [3:0] S_SSPD   = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  // what a multiply-divide result feeds
  localparam logic [1:0] T_INST = 2'd0;
  localparam logic [1:0] T_POS  = 2'd1;
  localparam logic [1:0] T_SPD  = 2'd2;

  localparam int RB = eut_pkg::RawBits;
  localparam int DW = eut_pkg::DiffW;

  // configuration
  logic [15:0] cpr_q;
  logic        inv_q;
  logic [16:0] gain_q;
  logic [1:0]  unit_q;

  // tracker state
  logic [RB-1:0]       prev_q;
  logic [31:0]         count_q;
  logic signed [47:0]  speed_q;
  logic signed [47:0]  inst_q;
  logic signed [47:0]  angle_res_q;
  logic signed [47:0]  speed_res_q;
  logic                upd_q;

  // sequencer and shared unit operands
  logic [3:0]                  state_q;
  logic [eut_pkg::MagW-1:0]    md_a_q;
  logic [31:0]                 md_m_q;
  logic [eut_pkg::DivW-1:0]    md_d_q;
  logic                        md_neg_q;
  logic [1:0]                  md_tgt_q;
  logic [eut_pkg::ProdW-1:0]   acc_q;
  logic signed [65:0]          sm_acc_q;

  // output word
  logic               out_valid_q;
  logic signed [31:0] out_count_q;
  logic signed [47:0] out_angle_q;
  logic signed [47:0] out_speed_q;
  logic               out_upd_q;

  // effective counts per revolution and half turn
  logic [15:0]         cpr;
  logic signed [DW-1:0] cpr_s;
  logic signed [DW-1:0] half_s;
  logic [RB-1:0]        raw;
  logic signed [DW-1:0] diff0;
  logic signed [DW-1:0] diff1;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_mag;

  logic [31:0]               unit_m;
  logic [eut_pkg::DivW-1:0]  unit_d;
  logic [eut_pkg::MagW-1:0]  tc_mag;
  logic [eut_pkg::MagW-1:0]  spd_mag;
  logic [16:0]               gain_a;
  logic [16:0]               gain_b;

  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  mul_p;
  logic signed [65:0]  sm_round;
  logic [47:0]         md_res;

  eut_pkg::div_req_t div_req;
  eut_pkg::div_rsp_t div_rsp;

  logic in_take;

  assign cpr = (cpr_q < 16'd2) ? 16'd2 : ((cpr_q > 16'd32768) ? 16'd32768 : cpr_q);
  assign cpr_s  = $signed({2'b00, cpr});
  assign half_s = $signed({3'b000, cpr[15:1]});
  assign raw    = raw_angle_i[RB-1:0];

  // wrap the step into half a turn, once from each side
  assign diff0 = $signed({{(DW-RB){1'b0}}, raw}) - $signed({{(DW-RB){1'b0}}, prev_q});
  assign diff1 = (diff0 > half_s) ? diff0 - cpr_s : diff0;
  assign diff  = (diff1 < -half_s) ? diff1 + cpr_s : diff1;
  assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);

  always_comb begin
    unique case (unit_q)
      eut_pkg::UnitDeg: begin
        unit_m = eut_pkg::MulDeg;
        unit_d = {12'd0, cpr};
      end
      eut_pkg::UnitRad: begin
        unit_m = eut_pkg::MulRad;
        unit_d = {cpr, 12'd0};
      end
      eut_pkg::UnitRot: begin
        unit_m = eut_pkg::MulRot;
        unit_d = {12'd0, cpr};
      end
      default: begin
        unit_m = '0;
        unit_d = '0;
      end
    endcase
  end

  assign tc_mag  = {17'd0, count_q[31] ? (~count_q + 32'd1) : count_q};
  assign spd_mag = {1'b0, speed_q[47] ? (~speed_q + 48'd1) : speed_q};
  assign gain_a  = (gain_q > eut_pkg::QOne) ? eut_pkg::QOne : gain_q;
  assign gain_b  = eut_pkg::QOne - gain_a;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MLO: begin
        mul_a = $signed({1'b0, md_a_q[31:0]});
        mul_b = $signed({1'b0, md_m_q});
      end
      S_MHI: begin
        mul_a = $signed({16'd0, md_a_q[48:32]});
        mul_b = $signed({1'b0, md_m_q});
      end
      S_SM0: begin
        mul_a = $signed({16'd0, gain_b});
        mul_b = $signed({1'b0, speed_q[31:0]});
      end
      S_SM1: begin
        mul_a = $signed({16'd0, gain_b});
        mul_b = $signed({{17{speed_q[47]}}, speed_q[47:32]});
      end
      S_SM2: begin
        mul_a = $signed({16'd0, gain_a});
        mul_b = $signed({1'b0, inst_q[31:0]});
      end
      S_SM3: begin
        mul_a = $signed({16'd0, gain_a});
        mul_b = $signed({{17{inst_q[47]}}, inst_q[47:32]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  eut_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign div_req.start    = (state_q == S_DSTART);
  assign div_req.dividend = acc_q;
  assign div_req.divisor  = md_d_q;

  eut_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign md_res   = eut_pkg::sign_sat(div_rsp.mag, md_neg_q);
  // floor of (acc + half lsb) / 2^16
  assign sm_round = sm_acc_q + 66'sd32768;
  assign in_take  = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q       <= 16'd4096;
      inv_q       <= 1'b0;
      gain_q      <= 17'd6554;
      unit_q      <= eut_pkg::UnitDeg;
      prev_q      <= '0;
      count_q     <= '0;
      speed_q     <= '0;
      inst_q      <= '0;
      angle_res_q <= '0;
      speed_res_q <= '0;
      upd_q       <= 1'b0;
      state_q     <= S_IDLE;
      md_a_q      <= '0;
      md_m_q      <= '0;
      md_d_q      <= '0;
      md_neg_q    <= 1'b0;
      md_tgt_q    <= T_INST;
      acc_q       <= '0;
      sm_acc_q    <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      out_angle_q <= '0;
      out_speed_q <= '0;
      out_upd_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          eut_pkg::RegCpr:  cpr_q  <= cfg_data_i[15:0];
          eut_pkg::RegInv:  inv_q  <= cfg_data_i[0];
          eut_pkg::RegGain: gain_q <= cfg_data_i;
          eut_pkg::RegUnit: unit_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end

      // the output state refills the slot itself
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            if (command_i) begin
              // zero calibration
              prev_q  <= raw;
              count_q <= '0;
              speed_q <= '0;
              upd_q   <= 1'b1;
              state_q <= S_SPOS;
            end else if (dt_us_i == 20'd0) begin
              upd_q   <= 1'b0;
              state_q <= S_SPOS;
            end else begin
              prev_q   <= raw;
              count_q  <= count_q + {{(32-DW){diff[DW-1]}}, diff};
              upd_q    <= 1'b1;
              md_a_q   <= {{(eut_pkg::MagW-DW-16){1'b0}}, diff_mag, 16'd0};
              md_neg_q <= diff[DW-1];
              md_m_q   <= eut_pkg::UsPerSec;
              md_d_q   <= {8'd0, dt_us_i};
              md_tgt_q <= T_INST;
              state_q  <= S_MLO;
            end
          end
        end
        S_MLO: state_q <= S_MHI;
        S_MHI: begin
          acc_q   <= {16'd0, mul_p[63:0]};
          state_q <= S_MACC;
        end
        S_MACC: begin
          acc_q   <= acc_q + {mul_p[47:0], 32'd0};
          state_q <= S_DSTART;
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            case (md_tgt_q)
              T_INST: begin
                inst_q  <= $signed(md_res);
                state_q <= S_SM0;
              end
              T_POS: begin
                angle_res_q <= $signed(md_res);
                state_q     <= S_SSPD;
              end
              default: begin
                speed_res_q <= $signed(md_res);
                state_q     <= S_OUT;
              end
            endcase
          end
        end
        S_SM0: state_q <= S_SM1;
        S_SM1: begin
          sm_acc_q <= mul_p;
          state_q  <= S_SM2;
        end
        S_SM2: begin
          sm_acc_q <= sm_acc_q + (mul_p <<< 32);
          state_q  <= S_SM3;
        end
        S_SM3: begin
          sm_acc_q <= sm_acc_q + mul_p;
          state_q  <= S_SM4;
        end
        S_SM4: begin
          sm_acc_q <= sm_acc_q + (mul_p <<< 32);
          state_q  <= S_SM5;
        end
        S_SM5: begin
          speed_q <= $signed(sm_round[63:16]);
          state_q <= S_SPOS;
        end
        S_SPOS: begin
          if (unit_q != eut_pkg::UnitDeg && unit_q != eut_pkg::UnitRad &&
              unit_q != eut_pkg::UnitRot) begin
            // unused unit code reports zero
            angle_res_q <= '0;
            speed_res_q <= '0;
            state_q     <= S_OUT;
          end else begin
            md_a_q   <= tc_mag;
            md_neg_q <= count_q[31] ^ inv_q;
            md_m_q   <= unit_m;
            md_d_q   <= unit_d;
            md_tgt_q <= T_POS;
            state_q  <= S_MLO;
          end
        end
        S_SSPD: begin
          md_a_q   <= spd_mag;
          md_neg_q <= speed_q[47] ^ inv_q;
          md_tgt_q <= T_SPD;
          state_q  <= S_MLO;
        end
        S_OUT: begin
          // hold until the output slot is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_count_q <= $signed(count_q);
            out_angle_q <= angle_res_q;
            out_speed_q <= speed_res_q;
            out_upd_q   <= upd_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign turn_count_o  = out_count_q;
  assign angle_value_o = out_angle_q;
  assign speed_value_o = out_speed_q;
  assign updated_o     = out_upd_q;

endmodule
`default_nettype wire
